/* rtl/csws_pkg.sv */
// Shared widths, types and operation codes for the byte stack with search.
`timescale 1ns / 1ps
package csws_pkg;
	localparam int StackDepth  = 32;
	localparam int AddrW       = $clog2(StackDepth);
	localparam int CountW      = $clog2(StackDepth + 1);
	localparam int OpW         = 3;
	localparam int ByteW       = 8;
	localparam int EntryCountW = 6;
	localparam int ErrW        = 2;

	typedef logic [OpW-1:0]         op_t;
	typedef logic [ByteW-1:0]       byte_t;
	typedef logic [EntryCountW-1:0] entry_count_t;
	typedef logic [ErrW-1:0]        err_t;
	typedef logic [CountW-1:0]      count_t;
	typedef logic [AddrW-1:0]       addr_t;

	localparam op_t OP_PUSH  = 3'd0;
	localparam op_t OP_POP   = 3'd1;
	localparam op_t OP_QUERY = 3'd2;
	localparam op_t OP_SPLIT = 3'd3;
	localparam op_t OP_DUMP  = 3'd4;

	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_OVERFLOW  = 2'd1;
	localparam err_t ERR_UNDERFLOW = 2'd2;
endpackage

/* rtl/csws_cmd_if.sv */
// Command channel: operation and byte operand, valid/ready handshake.
`timescale 1ns / 1ps
interface csws_cmd_if;
	logic           valid;
	logic           ready;
	csws_pkg::op_t  operation;
	csws_pkg::byte_t byte_value;

	modport source (output valid, output operation, output byte_value, input ready);
	modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

/* rtl/csws_rsp_if.sv */
// Result channel: popped/dumped byte plus stack status, valid/ready handshake.
`timescale 1ns / 1ps
interface csws_rsp_if;
	logic                   valid;
	logic                   ready;
	csws_pkg::byte_t        data_byte;
	logic                   data_valid;
	csws_pkg::byte_t        top_byte;
	logic                   top_valid;
	csws_pkg::byte_t        second_byte;
	logic                   second_valid;
	csws_pkg::entry_count_t entry_count;
	logic                   key_found;
	csws_pkg::err_t         error_code;
	logic                   last_result;

	modport source (output valid, output data_byte, output data_valid, output top_byte,
		output top_valid, output second_byte, output second_valid, output entry_count,
		output key_found, output error_code, output last_result, input ready);
	modport sink   (input valid, input data_byte, input data_valid, input top_byte,
		input top_valid, input second_byte, input second_valid, input entry_count,
		input key_found, input error_code, input last_result, output ready);
endinterface

/* rtl/char_stack_with_search_split.sv */
// Bounded byte stack with push, pop, key search, split at separator and dump.
// Push and unknown codes hand over a single beat; every command reads the top and
//   second entries for its status, and pop and dump then read each entry to emit.
//   Query compares every stored entry; split inspects entries from the top down.
// Split and dump emit their beats in turn, each held until rsp.ready is high; all work
//   goes through the single read port of the entry memory, one read per cycle.
// A new command is accepted the cycle after the last beat of the previous one.
// Reset clears the entry count and sequencer; the entry memory is not cleared.
`timescale 1ns / 1ps
module char_stack_with_search_split (
	input logic         clk,
	input logic         arst_n,
	csws_cmd_if.sink    cmd,
	csws_rsp_if.source  rsp
);
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_QRY_RD  = 4'd1;
	localparam logic [3:0] S_QRY_CMP = 4'd2;
	localparam logic [3:0] S_SPL_RD  = 4'd3;
	localparam logic [3:0] S_SPL_CMP = 4'd4;
	localparam logic [3:0] S_TOP_RD  = 4'd5;
	localparam logic [3:0] S_SEC_RD  = 4'd6;
	localparam logic [3:0] S_SEC_CAP = 4'd7;
	localparam logic [3:0] S_EM_RD   = 4'd8;
	localparam logic [3:0] S_EM_LD   = 4'd9;
	localparam logic [3:0] S_OUT     = 4'd10;

	localparam csws_pkg::count_t FullCount = csws_pkg::CountW'(csws_pkg::StackDepth);
	localparam csws_pkg::count_t One       = csws_pkg::CountW'(1);
	localparam csws_pkg::count_t Two       = csws_pkg::CountW'(2);

	logic [3:0]          state_q;
	csws_pkg::count_t    cnt_q;
	csws_pkg::count_t    ptr_q;
	csws_pkg::count_t    em_ptr_q;
	csws_pkg::op_t       op_q;
	csws_pkg::byte_t     key_q;
	logic                has_data_q;
	logic                found_q;
	csws_pkg::err_t      err_q;
	logic                last_q;
	csws_pkg::byte_t     data_q;
	csws_pkg::byte_t     top_q;
	csws_pkg::byte_t     second_q;

	csws_pkg::byte_t     stack_mem [csws_pkg::StackDepth];
	csws_pkg::byte_t     rd_data_q;
	csws_pkg::count_t    rd_ptr;
	logic                wr_en;

	csws_pkg::count_t    em_next;
	csws_pkg::count_t    em_lo;

	assign em_next = em_ptr_q - One;
	assign em_lo   = (op_q == csws_pkg::OP_DUMP) ? '0 : cnt_q;
	assign wr_en   = (state_q == S_IDLE) && cmd.valid &&
		(cmd.operation == csws_pkg::OP_PUSH) && (cnt_q != FullCount);

	// Read address of the single memory port, chosen by the sequencer step.
	always_comb begin
		unique case (state_q)
			S_QRY_RD: rd_ptr = ptr_q;
			S_SPL_RD: rd_ptr = ptr_q - One;
			S_TOP_RD: rd_ptr = cnt_q - One;
			S_SEC_RD: rd_ptr = cnt_q - Two;
			S_EM_RD:  rd_ptr = em_next;
			default:  rd_ptr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[cnt_q[csws_pkg::AddrW-1:0]] <= cmd.byte_value;
		end
		rd_data_q <= stack_mem[rd_ptr[csws_pkg::AddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			em_ptr_q   <= '0;
			has_data_q <= 1'b0;
			found_q    <= 1'b0;
			err_q      <= csws_pkg::ERR_NONE;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q       <= cmd.operation;
						key_q      <= cmd.byte_value;
						found_q    <= 1'b0;
						err_q      <= csws_pkg::ERR_NONE;
						has_data_q <= 1'b0;
						em_ptr_q   <= cnt_q;
						ptr_q      <= '0;
						state_q    <= S_TOP_RD;
						case (cmd.operation)
							csws_pkg::OP_PUSH: begin
								if (cnt_q == FullCount) begin
									err_q <= csws_pkg::ERR_OVERFLOW;
								end else begin
									cnt_q <= cnt_q + One;
								end
							end
							csws_pkg::OP_POP: begin
								if (cnt_q == '0) begin
									err_q <= csws_pkg::ERR_UNDERFLOW;
								end else begin
									cnt_q      <= cnt_q - One;
									has_data_q <= 1'b1;
								end
							end
							csws_pkg::OP_QUERY: begin
								if (cnt_q != '0) begin
									state_q <= S_QRY_RD;
								end
							end
							csws_pkg::OP_SPLIT: begin
								ptr_q <= cnt_q;
								if (cnt_q != '0) begin
									state_q <= S_SPL_RD;
								end
							end
							csws_pkg::OP_DUMP: begin
								has_data_q <= (cnt_q != '0);
							end
							default: begin
							end
						endcase
					end
				end
				S_QRY_RD: state_q <= S_QRY_CMP;
				S_QRY_CMP: begin
					if (rd_data_q == key_q) begin
						found_q <= 1'b1;
					end
					ptr_q   <= ptr_q + One;
					state_q <= (ptr_q + One == cnt_q) ? S_TOP_RD : S_QRY_RD;
				end
				S_SPL_RD: state_q <= S_SPL_CMP;
				S_SPL_CMP: begin
					// Stop at the separator, leaving it on the stack, or at the bottom.
					if (rd_data_q == key_q) begin
						cnt_q      <= ptr_q;
						has_data_q <= (ptr_q != em_ptr_q);
						state_q    <= S_TOP_RD;
					end else if (ptr_q == One) begin
						cnt_q      <= '0;
						has_data_q <= 1'b1;
						state_q    <= S_TOP_RD;
					end else begin
						ptr_q   <= ptr_q - One;
						state_q <= S_SPL_RD;
					end
				end
				S_TOP_RD: state_q <= S_SEC_RD;
				S_SEC_RD: begin
					top_q   <= (cnt_q >= One) ? rd_data_q : '0;
					state_q <= S_SEC_CAP;
				end
				S_SEC_CAP: begin
					second_q <= (cnt_q >= Two) ? rd_data_q : '0;
					if (has_data_q) begin
						state_q <= S_EM_RD;
					end else begin
						data_q  <= '0;
						last_q  <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: begin
					data_q   <= rd_data_q;
					last_q   <= (em_next == em_lo);
					em_ptr_q <= em_next;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= last_q ? S_IDLE : S_EM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready        = (state_q == S_IDLE);
	assign rsp.valid        = (state_q == S_OUT);
	assign rsp.data_byte    = data_q;
	assign rsp.data_valid   = has_data_q;
	assign rsp.top_byte     = top_q;
	assign rsp.top_valid    = (cnt_q >= One);
	assign rsp.second_byte  = second_q;
	assign rsp.second_valid = (cnt_q >= Two);
	assign rsp.entry_count  = csws_pkg::EntryCountW'(cnt_q);
	assign rsp.key_found    = found_q;
	assign rsp.error_code   = err_q;
	assign rsp.last_result  = last_q;
endmodule

/* rtl/csws_check.sv */
// Port-level checks for the byte stack, attached to the top level by bind.
`timescale 1ns / 1ps
module csws_check (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input csws_pkg::byte_t        rsp_data_byte,
	input logic                   rsp_data_valid,
	input logic                   rsp_top_valid,
	input logic                   rsp_second_valid,
	input csws_pkg::entry_count_t rsp_entry_count,
	input logic                   rsp_last_result
);
	// One command in flight: no new beat is taken while results are pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && rsp_valid))
		else $error("command ready while a result beat is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready held after a command beat was accepted");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp_second_valid || rsp_top_valid) &&
		(rsp_data_valid || rsp_data_byte == '0) && (rsp_data_valid || rsp_last_result))
		else $error("inconsistent status fields on a result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
		$stable(rsp_entry_count) && $stable(rsp_last_result))
		else $error("stalled result beat changed");
endmodule

bind char_stack_with_search_split csws_check u_csws_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_data_byte    (rsp.data_byte),
	.rsp_data_valid   (rsp.data_valid),
	.rsp_top_valid    (rsp.top_valid),
	.rsp_second_valid (rsp.second_valid),
	.rsp_entry_count  (rsp.entry_count),
	.rsp_last_result  (rsp.last_result)
);
